/* hdl/ssw_pkg.sv */
// ----------------------------------------------------------------------------
// Solovay-Strassen witness package
// Shared widths and the status struct between the datapath and the sequencer.
// ----------------------------------------------------------------------------
package ssw_pkg;

    localparam int MOD_BITS = 16;
    localparam int CNT_BITS = $clog2(MOD_BITS + 1);

    // Status that the shared datapath reports to the sequencer.
    typedef struct packed {
        logic a_zero;     // Jacobi numerator is zero
        logic a_even;     // Jacobi numerator is even
        logic done;       // current iterative operation finished
    } ssw_stat_t;

    // Operations that the sequencer issues to the datapath.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // latch operands
        OP_RED,       // one restoring-division step of base mod n
        OP_JHALF,     // halve the Jacobi numerator
        OP_JSWAP,     // swap numerator and denominator
        OP_JMOD,      // one division step of a mod m
        OP_EINIT,     // start exponentiation
        OP_MMUL,      // one shift-add step of modular multiply
        OP_ESTEP      // advance to the next exponent bit
    } ssw_op_t;

endpackage

/* hdl/ssw_datapath.sv */
// ----------------------------------------------------------------------------
// Solovay-Strassen datapath
// Registers and one shared modular add/subtract unit used by the modular multiply steps.
// ----------------------------------------------------------------------------
module ssw_datapath
    import ssw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ssw_op_t             op,
    input  logic [MOD_BITS-1:0] in_n,
    input  logic [MOD_BITS-1:0] in_b,
    output ssw_stat_t           stat,
    output logic                n_invalid,
    output logic                sign_neg,
    output logic                m_is_one,
    output logic                y_match_pos,
    output logic                y_match_neg,
    output logic                exp_zero,
    output logic                mul_pending
);

    logic [MOD_BITS-1:0] n_reg, n_next;
    logic [MOD_BITS-1:0] a_reg, a_next;       // Jacobi numerator, also base
    logic [MOD_BITS-1:0] m_reg, m_next;       // Jacobi denominator
    logic [MOD_BITS-1:0] rem_reg, rem_next;   // division remainder
    logic [MOD_BITS-1:0] quo_reg, quo_next;   // dividend shift register
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [MOD_BITS-1:0] bse_reg, bse_next;   // exponent base
    logic [MOD_BITS-1:0] y_reg, y_next;       // exponent result
    logic [MOD_BITS-1:0] e_reg, e_next;       // remaining exponent
    logic [MOD_BITS-1:0] ma_reg, ma_next;     // multiply addend
    logic [MOD_BITS-1:0] mb_reg, mb_next;     // multiply multiplier bits
    logic [MOD_BITS-1:0] acc_reg, acc_next;   // multiply accumulator
    logic                sq_reg, sq_next;     // 0: y*base, 1: base*base
    logic                sgn_reg, sgn_next;

    // Shared unit: add_mod(x, y, mod) and compare.
    logic [MOD_BITS-1:0] u_x, u_y, u_m, u_out, u_gap;
    logic [MOD_BITS:0]   d_shift;
    logic [MOD_BITS-1:0] d_mod;

    always_comb begin
        u_gap = u_m - u_y;
        u_out = (u_x >= u_gap) ? (u_x - u_gap) : (u_x + u_y);
    end

    // Operand selection for the shared unit.
    always_comb begin
        u_x = acc_reg;
        u_y = ma_reg;
        u_m = n_reg;
        if (op == OP_MMUL && !mb_reg[0]) begin
            u_x = ma_reg;
        end
        if (op == OP_MMUL && mb_reg[0]) begin
            u_x = acc_reg;
        end
    end

    // Division step divisor: base mod n uses n, Jacobi reduction uses m.
    assign d_mod   = (op == OP_RED) ? n_reg : m_reg;
    assign d_shift = {rem_reg, quo_reg[MOD_BITS-1]};

    always_comb begin
        n_next   = n_reg;
        a_next   = a_reg;
        m_next   = m_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        bse_next = bse_reg;
        y_next   = y_reg;
        e_next   = e_reg;
        ma_next  = ma_reg;
        mb_next  = mb_reg;
        acc_next = acc_reg;
        sq_next  = sq_reg;
        sgn_next = sgn_reg;
        unique case (op)
            OP_LOAD: begin
                n_next   = in_n;
                quo_next = in_b;
                rem_next = '0;
                cnt_next = CNT_BITS'(MOD_BITS);
                sgn_next = 1'b0;
            end
            OP_RED, OP_JMOD: begin
                // One restoring-division step; remainder ends in rem_reg.
                quo_next = {quo_reg[MOD_BITS-2:0], 1'b0};
                if (d_shift >= {1'b0, d_mod}) begin
                    rem_next = MOD_BITS'(d_shift - {1'b0, d_mod});
                end else begin
                    rem_next = d_shift[MOD_BITS-1:0];
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1)) begin
                    a_next = (d_shift >= {1'b0, d_mod}) ?
                             MOD_BITS'(d_shift - {1'b0, d_mod}) : d_shift[MOD_BITS-1:0];
                    // The reduced base is kept for the exponentiation.
                    if (op == OP_RED) begin
                        m_next   = n_reg;
                        bse_next = a_next;
                    end
                end
            end
            OP_JHALF: begin
                a_next = {1'b0, a_reg[MOD_BITS-1:1]};
                if (m_reg[2:0] == 3'd3 || m_reg[2:0] == 3'd5) begin
                    sgn_next = ~sgn_reg;
                end
            end
            OP_JSWAP: begin
                // Swap, flip on both three mod four, and start a mod m.
                a_next   = m_reg;
                m_next   = a_reg;
                if (m_reg[1:0] == 2'b11 && a_reg[1:0] == 2'b11) begin
                    sgn_next = ~sgn_reg;
                end
                quo_next = m_reg;
                rem_next = '0;
                cnt_next = CNT_BITS'(MOD_BITS);
            end
            OP_EINIT: begin
                y_next   = MOD_BITS'(1);
                e_next   = {1'b0, n_reg[MOD_BITS-1:1]};
                sq_next  = 1'b0;
                ma_next  = bse_reg;
                mb_next  = MOD_BITS'(1);
                acc_next = '0;
                // Exponent bit zero skips straight to squaring.
                if (!n_reg[1]) begin
                    sq_next = 1'b1;
                    mb_next = bse_reg;
                end else begin
                    mb_next = y_next;
                end
            end
            OP_MMUL: begin
                if (mb_reg[0]) begin
                    acc_next = u_out;
                end else begin
                    ma_next = u_out;
                end
                if (mb_reg[0]) begin
                    ma_next = ma_reg;
                    mb_next = mb_reg;
                    mb_next[0] = 1'b0;
                end else begin
                    mb_next = {1'b0, mb_reg[MOD_BITS-1:1]};
                end
            end
            OP_ESTEP: begin
                // Store the product and set up the next multiply.
                if (sq_reg) begin
                    bse_next = acc_reg;
                    e_next   = {1'b0, e_reg[MOD_BITS-1:1]};
                    if (e_reg[1]) begin
                        sq_next = 1'b0;
                        ma_next = y_reg;
                        mb_next = acc_reg;
                    end else begin
                        sq_next = 1'b1;
                        ma_next = acc_reg;
                        mb_next = acc_reg;
                    end
                end else begin
                    y_next  = acc_reg;
                    sq_next = 1'b1;
                    ma_next = bse_reg;
                    mb_next = bse_reg;
                end
                acc_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            sgn_reg <= 1'b0;
            sq_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            sgn_reg <= sgn_next;
            sq_reg  <= sq_next;
        end
        n_reg   <= n_next;
        a_reg   <= a_next;
        m_reg   <= m_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        bse_reg <= bse_next;
        y_reg   <= y_next;
        e_reg   <= e_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        acc_reg <= acc_next;
    end

    // Status for the sequencer.
    assign stat.a_zero  = (a_reg == '0);
    assign stat.a_even  = ~a_reg[0];
    assign stat.done    = (cnt_reg == CNT_BITS'(1));
    assign n_invalid    = (n_reg < MOD_BITS'(3)) || !n_reg[0];
    assign sign_neg     = sgn_reg;
    assign m_is_one     = (m_reg == MOD_BITS'(1));
    assign y_match_pos  = (y_reg == MOD_BITS'(1));
    assign y_match_neg  = (y_reg == n_reg - MOD_BITS'(1));
    assign exp_zero     = sq_reg ? (e_reg == '0) : 1'b0;
    assign mul_pending  = (mb_reg != '0);

endmodule

/* hdl/solovay_strassen_witness.sv */
// Sequence: an invalid modulus goes from the check state straight to the result;
// otherwise base reduction, then Jacobi halving and swap steps (each swap followed by
// a division), then the modular multiplies of the exponentiation.
// Throughput: one word at a time; s_tready is low from acceptance until the
// result word is taken. The shared modular adder and divider step set this.
// Reset: synchronous active-low aresetn returns the sequencer to idle with
// no result pending.
// ----------------------------------------------------------------------------
// Solovay-Strassen witness
// Jacobi symbol and Euler criterion check under a small sequencer.
// ----------------------------------------------------------------------------
module solovay_strassen_witness
    import ssw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // modulus[15:0], base[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // is_witness[0], jacobi_symbol[2:1], bad_modulus[3]
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_RED, ST_JTEST, ST_JMOD, ST_EINIT,
        ST_MUL, ST_ESTEP, ST_OUT
    } state_t;

    state_t          state_reg;
    ssw_op_t         op;
    ssw_stat_t       stat;
    logic            n_invalid;
    logic            sign_neg, m_is_one, y_pos, y_neg, exp_zero, mul_pending;
    logic [3:0]      res_reg;
    logic [MOD_BITS-1:0] n_in;

    assign n_in = s_tdata[MOD_BITS-1:0];

    ssw_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .op(op),
        .in_n(n_in), .in_b(s_tdata[16+MOD_BITS-1:16]),
        .stat(stat), .n_invalid(n_invalid),
        .sign_neg(sign_neg), .m_is_one(m_is_one),
        .y_match_pos(y_pos), .y_match_neg(y_neg),
        .exp_zero(exp_zero), .mul_pending(mul_pending)
    );

    // Operation issued in each state.
    always_comb begin
        op = OP_NONE;
        unique case (state_reg)
            ST_IDLE:  op = s_tvalid ? OP_LOAD : OP_NONE;
            ST_RED:   op = OP_RED;
            ST_JTEST: op = stat.a_zero ? OP_NONE : (stat.a_even ? OP_JHALF : OP_JSWAP);
            ST_JMOD:  op = OP_JMOD;
            ST_EINIT: op = OP_EINIT;
            ST_MUL:   op = mul_pending ? OP_MMUL : OP_ESTEP;
            default:  op = OP_NONE;
        endcase
    end

    // Sequencer and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            res_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (n_invalid) begin
                        res_reg   <= 4'b1000;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_RED;
                    end
                end
                ST_RED: begin
                    if (stat.done) begin
                        state_reg <= ST_JTEST;
                    end
                end
                ST_JTEST: begin
                    if (stat.a_zero) begin
                        if (!m_is_one) begin
                            res_reg   <= 4'b0001;
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_EINIT;
                        end
                    end else if (!stat.a_even) begin
                        state_reg <= ST_JMOD;
                    end
                end
                ST_JMOD: begin
                    if (stat.done) begin
                        state_reg <= ST_JTEST;
                    end
                end
                ST_EINIT: state_reg <= ST_MUL;
                ST_MUL: begin
                    if (!mul_pending) begin
                        state_reg <= ST_ESTEP;
                    end
                end
                ST_ESTEP: begin
                    if (exp_zero) begin
                        res_reg <= sign_neg ? {2'b01, 1'b1, ~y_neg}
                                            : {2'b00, 1'b1, ~y_pos};
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {4'b0, res_reg};

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    a_bad_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[2:0] == 3'b000)
        else $error("bad modulus with nonzero fields");
    a_sym_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:1] != 2'b10) else $error("illegal symbol code");
`endif

endmodule
